// ===== hw/rtl/qpp_pkg.sv =====
// ----------------------------------------------------------------------------
// qpp_pkg
// shared types, codes and character tables of the query parameter parser
// ----------------------------------------------------------------------------
package qpp_pkg;

    localparam int COORD_WIDTH = 16;

    typedef logic [COORD_WIDTH-1:0] t_coord;

    // result status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_ROUTE   = 3'd1;
    localparam logic [2:0] ST_NO_QM   = 3'd2;
    localparam logic [2:0] ST_FORMAT  = 3'd3;
    localparam logic [2:0] ST_NON_NUM = 3'd4;
    localparam logic [2:0] ST_RANGE   = 3'd5;

    // output format codes
    localparam logic [1:0] FMT_PNG  = 2'd0;
    localparam logic [1:0] FMT_TEXT = 2'd1;
    localparam logic [1:0] FMT_BIN  = 2'd2;
    localparam logic [1:0] FMT_JSON = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_DEF_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_DEF_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_LIMIT      = 2'd2;

    localparam logic [15:0] RST_DEF_WIDTH  = 16'd1920;
    localparam logic [15:0] RST_DEF_HEIGHT = 16'd1080;
    localparam logic [15:0] RST_LIMIT      = 16'd10000;

    // parameter codes: 1 width, 2 height, 3 left, 4 x, 5 top, 6 y, 7 format
    localparam logic [2:0] PARAM_FORMAT = 3'd7;

    localparam logic [7:0] NAME_TBL [0:6][0:7] = '{
        '{"w", "i", "d", "t", "h", "=", 8'h00, 8'h00},
        '{"h", "e", "i", "g", "h", "t", "=", 8'h00},
        '{"l", "e", "f", "t", "=", 8'h00, 8'h00, 8'h00},
        '{"x", "=", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"t", "o", "p", "=", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"y", "=", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"f", "o", "r", "m", "a", "t", "=", 8'h00}
    };

    localparam logic [3:0] NAME_LEN [0:6] = '{4'd6, 4'd7, 4'd5, 4'd2, 4'd4, 4'd2, 4'd7};

    localparam logic [7:0] PIXEL_TBL [0:7] = '{"/", "p", "i", "x", "e", "l", "/", 8'h00};

    // coordinate slot per parameter code: 0 left, 1 top, 2 width, 3 height
    localparam logic [1:0] PARAM_SLOT [0:7] = '{2'd0, 2'd2, 2'd3, 2'd0, 2'd0, 2'd1, 2'd1, 2'd0};

    typedef struct packed {
        logic [2:0]  status;
        logic        region_flag;
        logic [1:0]  format_code;
        logic [15:0] left_out;
        logic [15:0] top_out;
        logic [15:0] width_out;
        logic [15:0] height_out;
    } t_result;

    function automatic t_coord to_coord(input logic [15:0] v);
        logic [47:0] w;
        w = {32'd0, v};
        return w[COORD_WIDTH-1:0];
    endfunction

    function automatic logic [15:0] from_coord(input t_coord c);
        logic [47:0] w;
        w = 48'(c);
        return w[15:0];
    endfunction

endpackage

// ===== hw/rtl/qpp_parser.sv =====
// ----------------------------------------------------------------------------
// qpp_parser
// per-byte route and parameter parser, one byte per cycle
// ----------------------------------------------------------------------------
module qpp_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [7:0]        i_byte,
    input  logic              i_first,
    input  logic              i_last,
    input  logic [15:0]       i_def_width,
    input  logic [15:0]       i_def_height,
    input  logic [15:0]       i_limit,
    output logic              o_res_valid,
    output qpp_pkg::t_result  o_res
);

    localparam logic [3:0] PH_IDLE   = 4'd0;
    localparam logic [3:0] PH_DONE   = 4'd1;
    localparam logic [3:0] PH_ROUTE1 = 4'd2;
    localparam logic [3:0] PH_PIXEL  = 4'd3;
    localparam logic [3:0] PH_AFTER  = 4'd4;
    localparam logic [3:0] PH_SEG    = 4'd5;
    localparam logic [3:0] PH_NAME   = 4'd6;
    localparam logic [3:0] PH_SKIP   = 4'd7;
    localparam logic [3:0] PH_FMT1   = 4'd8;
    localparam logic [3:0] PH_FMT2   = 4'd9;
    localparam logic [3:0] PH_VSIGN  = 4'd10;
    localparam logic [3:0] PH_VDIG   = 4'd11;

    localparam int FL_SIGN  = 0;
    localparam int FL_DIGIT = 1;
    localparam int FL_OVER  = 2;

    localparam logic [7:0] CH_SP  = 8'h20;
    localparam logic [7:0] CH_CR  = 8'h0d;
    localparam logic [7:0] CH_LF  = 8'h0a;
    localparam logic [7:0] CH_NUL = 8'h00;

    logic [3:0]           r_phase, n_phase;
    logic [2:0]           r_pos, n_pos;
    logic [6:0]           r_cand, n_cand;
    logic [2:0]           r_param, n_param;
    logic [15:0]          r_acc, n_acc;
    logic [2:0]           r_flags, n_flags;
    logic [7:0]           r_fmt_char, n_fmt_char;
    qpp_pkg::t_coord      r_coords [4];
    qpp_pkg::t_coord      n_coords [4];
    logic [1:0]           r_format, n_format;
    logic                 r_region, n_region;

    // end of a number: {error, status}
    function automatic logic [3:0] end_number(input logic [15:0] acc,
                                              input logic [2:0]  flags,
                                              input logic [15:0] limit);
        logic [3:0] r;
        r = {1'b0, qpp_pkg::ST_OK};
        if (!flags[FL_DIGIT])
            r = {1'b1, qpp_pkg::ST_NON_NUM};
        else if (flags[FL_OVER])
            r = {1'b1, qpp_pkg::ST_RANGE};
        else if (flags[FL_SIGN] && acc != 16'd0)
            r = {1'b1, qpp_pkg::ST_RANGE};
        else if (acc > limit)
            r = {1'b1, qpp_pkg::ST_RANGE};
        return r;
    endfunction

    logic        is_end;
    logic        is_digit;
    logic [19:0] dig_sum;
    logic [15:0] dig_acc;
    logic        dig_over;
    logic [2:0]  base_pos;
    logic [6:0]  base_cand;
    logic [6:0]  keep;
    logic [2:0]  hit;
    logic [7:0]  lo_b;
    logic [7:0]  lo_f;
    logic [3:0]  en_feed;
    logic [3:0]  en_fin;
    logic        fire;
    logic [2:0]  st;

    always_comb begin
        is_end   = (i_byte == CH_SP) || (i_byte == CH_CR) || (i_byte == CH_LF);
        is_digit = (i_byte >= "0") && (i_byte <= "9");
        lo_b     = i_byte | 8'h20;
        lo_f     = r_fmt_char | 8'h20;

        // saturating decimal accumulate
        dig_sum  = ({4'd0, r_acc} << 3) + ({4'd0, r_acc} << 1) + {16'd0, i_byte[3:0]};
        dig_over = dig_sum > {4'd0, i_limit};
        dig_acc  = dig_over ? i_limit : dig_sum[15:0];

        // name matching starts fresh on the first byte of a segment
        base_pos  = (r_phase == PH_SEG) ? 3'd0 : r_pos;
        base_cand = (r_phase == PH_SEG) ? 7'h7f : r_cand;
        keep = '0;
        hit  = '0;
        for (int c = 0; c < 7; c++) begin
            if (base_cand[c] && ({1'b0, base_pos} < qpp_pkg::NAME_LEN[c]) &&
                qpp_pkg::NAME_TBL[c][base_pos] == i_byte) begin
                keep[c] = 1'b1;
                if ({1'b0, base_pos} + 4'd1 == qpp_pkg::NAME_LEN[c])
                    hit = 3'(c + 1);
            end
        end

        en_feed = end_number(r_acc, r_flags, i_limit);

        n_phase    = r_phase;
        n_pos      = r_pos;
        n_cand     = r_cand;
        n_param    = r_param;
        n_acc      = r_acc;
        n_flags    = r_flags;
        n_fmt_char = r_fmt_char;
        n_coords   = r_coords;
        n_format   = r_format;
        n_region   = r_region;
        fire       = 1'b0;
        st         = qpp_pkg::ST_OK;
        en_fin     = '0;

        if (i_valid) begin
            if (i_first) begin
                n_pos       = '0;
                n_cand      = 7'h7f;
                n_param     = '0;
                n_acc       = '0;
                n_flags     = '0;
                n_fmt_char  = '0;
                n_coords[0] = '0;
                n_coords[1] = '0;
                n_coords[2] = qpp_pkg::to_coord(i_def_width);
                n_coords[3] = qpp_pkg::to_coord(i_def_height);
                n_format    = qpp_pkg::FMT_PNG;
                n_region    = 1'b0;
                n_phase     = PH_ROUTE1;
                if (i_byte != "/") begin
                    fire = 1'b1;
                    st   = qpp_pkg::ST_ROUTE;
                end
            end else if (r_phase != PH_IDLE && r_phase != PH_DONE) begin
                unique case (r_phase)
                    PH_ROUTE1: begin
                        if (i_byte == CH_SP) begin
                            n_region = 1'b1;
                            fire     = 1'b1;
                        end else if (i_byte == "?") begin
                            n_region = 1'b1;
                            n_phase  = PH_SEG;
                        end else if (i_byte == "#") begin
                            fire = 1'b1;
                            st   = qpp_pkg::ST_NO_QM;
                        end else if (i_byte == "p") begin
                            n_phase = PH_PIXEL;
                            n_pos   = 3'd2;
                        end else begin
                            fire = 1'b1;
                            st   = qpp_pkg::ST_ROUTE;
                        end
                    end
                    PH_PIXEL: begin
                        if (r_pos != 3'd7 && i_byte == qpp_pkg::PIXEL_TBL[r_pos]) begin
                            n_pos = r_pos + 3'd1;
                            if (r_pos == 3'd6) begin
                                n_region = 1'b0;
                                n_phase  = PH_AFTER;
                            end
                        end else begin
                            fire = 1'b1;
                            st   = qpp_pkg::ST_ROUTE;
                        end
                    end
                    PH_AFTER: begin
                        if (i_byte == CH_SP) begin
                            fire = 1'b1;
                        end else if (i_byte == "?") begin
                            n_phase = PH_SEG;
                        end else begin
                            fire = 1'b1;
                            st   = qpp_pkg::ST_NO_QM;
                        end
                    end
                    PH_SEG, PH_NAME: begin
                        if (r_phase == PH_SEG && (is_end || i_byte == CH_NUL)) begin
                            fire = 1'b1;
                        end else if (r_phase == PH_SEG && i_byte == "&") begin
                            n_phase = PH_SEG;
                        end else if (is_end) begin
                            fire = 1'b1;
                        end else if (i_byte == "&") begin
                            n_phase = PH_SEG;
                            if (r_phase == PH_SEG) begin
                                n_pos  = '0;
                                n_cand = 7'h7f;
                            end
                        end else begin
                            n_phase = PH_NAME;
                            n_pos   = (base_pos != 3'd7) ? base_pos + 3'd1 : base_pos;
                            n_cand  = keep;
                            if (hit != 3'd0) begin
                                n_param = hit;
                                n_acc   = '0;
                                n_flags = '0;
                                n_phase = (hit == qpp_pkg::PARAM_FORMAT) ? PH_FMT1 : PH_VSIGN;
                            end else if (keep == 7'd0) begin
                                n_phase = PH_SKIP;
                            end
                        end
                    end
                    PH_SKIP: begin
                        if (is_end)
                            fire = 1'b1;
                        else
                            n_phase = (i_byte == "&") ? PH_SEG : PH_SKIP;
                    end
                    PH_FMT1: begin
                        if (lo_b == "t") begin
                            n_format = qpp_pkg::FMT_TEXT;
                            n_phase  = PH_SKIP;
                        end else if (lo_b == "p" || lo_b == "i" || lo_b == "b" ||
                                     lo_b == "j") begin
                            n_fmt_char = i_byte;
                            n_phase    = PH_FMT2;
                        end else begin
                            fire = 1'b1;
                            st   = qpp_pkg::ST_FORMAT;
                        end
                    end
                    PH_FMT2: begin
                        n_phase = PH_SKIP;
                        if ((lo_f == "p" && lo_b == "n") || (lo_f == "i" && lo_b == "m"))
                            n_format = qpp_pkg::FMT_PNG;
                        else if (lo_f == "b" && lo_b == "i")
                            n_format = qpp_pkg::FMT_BIN;
                        else if (lo_f == "j" && lo_b == "s")
                            n_format = qpp_pkg::FMT_JSON;
                        else begin
                            n_phase = r_phase;
                            fire    = 1'b1;
                            st      = qpp_pkg::ST_FORMAT;
                        end
                    end
                    PH_VSIGN: begin
                        if (i_byte == "+") begin
                            n_phase = PH_VDIG;
                        end else if (i_byte == "-") begin
                            n_flags[FL_SIGN] = 1'b1;
                            n_phase          = PH_VDIG;
                        end else if (is_digit) begin
                            n_acc             = dig_acc;
                            n_flags[FL_DIGIT] = 1'b1;
                            n_flags[FL_OVER]  = r_flags[FL_OVER] | dig_over;
                            n_phase           = PH_VDIG;
                        end else begin
                            fire = 1'b1;
                            st   = qpp_pkg::ST_NON_NUM;
                        end
                    end
                    PH_VDIG: begin
                        if (is_digit) begin
                            n_acc             = dig_acc;
                            n_flags[FL_DIGIT] = 1'b1;
                            n_flags[FL_OVER]  = r_flags[FL_OVER] | dig_over;
                        end else if (en_feed[3]) begin
                            fire = 1'b1;
                            st   = en_feed[2:0];
                        end else begin
                            n_coords[qpp_pkg::PARAM_SLOT[r_param]] = qpp_pkg::to_coord(r_acc);
                            if (is_end)
                                fire = 1'b1;
                            else
                                n_phase = (i_byte == "&") ? PH_SEG : PH_SKIP;
                        end
                    end
                    default: begin
                        n_phase = r_phase;
                    end
                endcase
            end

            // end of data acts as a terminator after this byte
            en_fin = end_number(n_acc, n_flags, i_limit);
            if (!fire && i_last && n_phase != PH_IDLE && n_phase != PH_DONE) begin
                fire = 1'b1;
                case (n_phase)
                    PH_ROUTE1, PH_PIXEL: st = qpp_pkg::ST_ROUTE;
                    PH_AFTER:            st = qpp_pkg::ST_NO_QM;
                    PH_FMT1, PH_FMT2:    st = qpp_pkg::ST_FORMAT;
                    PH_VSIGN:            st = qpp_pkg::ST_NON_NUM;
                    PH_VDIG: begin
                        if (en_fin[3])
                            st = en_fin[2:0];
                        else
                            n_coords[qpp_pkg::PARAM_SLOT[n_param]] = qpp_pkg::to_coord(n_acc);
                    end
                    default:             st = qpp_pkg::ST_OK;
                endcase
            end

            if (fire)
                n_phase = PH_DONE;
        end
    end

    always_comb begin
        o_res_valid = fire;
        o_res       = '0;
        o_res.status = st;
        if (st == qpp_pkg::ST_OK) begin
            o_res.region_flag = n_region;
            o_res.format_code = n_format;
            o_res.left_out    = qpp_pkg::from_coord(n_coords[0]);
            o_res.top_out     = qpp_pkg::from_coord(n_coords[1]);
            o_res.width_out   = qpp_pkg::from_coord(n_coords[2]);
            o_res.height_out  = qpp_pkg::from_coord(n_coords[3]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_pos      <= '0;
            r_cand     <= 7'h7f;
            r_param    <= '0;
            r_acc      <= '0;
            r_flags    <= '0;
            r_fmt_char <= '0;
            r_coords   <= '{default: '0};
            r_format   <= qpp_pkg::FMT_PNG;
            r_region   <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_pos      <= n_pos;
            r_cand     <= n_cand;
            r_param    <= n_param;
            r_acc      <= n_acc;
            r_flags    <= n_flags;
            r_fmt_char <= n_fmt_char;
            r_coords   <= n_coords;
            r_format   <= n_format;
            r_region   <= n_region;
        end
    end

endmodule

// ===== hw/rtl/qpp_out_fifo.sv =====
// ----------------------------------------------------------------------------
// qpp_out_fifo
// four-entry result queue between the parser and the output stream
// ----------------------------------------------------------------------------
module qpp_out_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  qpp_pkg::t_result  i_data,
    output logic              o_valid,
    input  logic              i_pop,
    output qpp_pkg::t_result  o_data,
    output logic [2:0]        o_level
);

    qpp_pkg::t_result r_mem [4];
    logic [1:0]       r_wr_ptr;
    logic [1:0]       r_rd_ptr;
    logic [2:0]       r_count;
    logic             do_pop;

    assign o_valid = (r_count != 3'd0);
    assign o_data  = r_mem[r_rd_ptr];
    assign o_level = r_count;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push)
            r_mem[r_wr_ptr] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push)
                r_wr_ptr <= r_wr_ptr + 2'd1;
            if (do_pop)
                r_rd_ptr <= r_rd_ptr + 2'd1;
            r_count <= r_count + {2'd0, i_push} - {2'd0, do_pop};
        end
    end

endmodule

// ===== hw/rtl/http_query_param_parser.sv =====
// ----------------------------------------------------------------------------
// http_query_param_parser
// parses the route and query parameters of an http request target
//
//  channel   dir  handshake               payload
//  s_axis    in   tvalid/tready           tdata[7:0] query_byte, tuser first_byte,
//                                         tlast last_byte
//  m_axis    out  tvalid/tready           tdata: status, region_flag, format_code,
//                                         left, top, width, height
//  cfg       in   i_cfg_we                i_cfg_idx, i_cfg_data
//
// one byte per cycle while tready is high; each accepted byte is held in the input register
// and its result, if any, enters the output queue at the next edge
// a result is valid on m_axis once its byte has passed the input register and the output queue
// tready drops only when the four-entry output queue could overflow
// synchronous active-low reset clears parse state and loads register defaults
// ----------------------------------------------------------------------------
module http_query_param_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] query_byte
    input  logic        s_axis_tuser,   // [0] first_byte
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // status, region_flag, format_code, left_out,
                                        // top_out, width_out, height_out, zero pad
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);

    logic [15:0]      r_def_width;
    logic [15:0]      r_def_height;
    logic [15:0]      r_limit;
    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic             r_in_first;
    logic             r_in_last;
    logic             accept;
    logic             res_valid;
    qpp_pkg::t_result res;
    qpp_pkg::t_result out_res;
    logic [2:0]       level;
    logic [3:0]       pending;

    // queued results plus the byte in flight must leave room for one more
    assign pending       = {1'b0, level} + {3'd0, r_in_valid};
    assign s_axis_tready = (pending <= 4'd3);
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_def_width  <= qpp_pkg::RST_DEF_WIDTH;
            r_def_height <= qpp_pkg::RST_DEF_HEIGHT;
            r_limit      <= qpp_pkg::RST_LIMIT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                qpp_pkg::CFG_DEF_WIDTH:  r_def_width  <= i_cfg_data;
                qpp_pkg::CFG_DEF_HEIGHT: r_def_height <= i_cfg_data;
                qpp_pkg::CFG_LIMIT:      r_limit      <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_in_valid <= 1'b0;
        else
            r_in_valid <= accept;
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_byte  <= s_axis_tdata;
            r_in_first <= s_axis_tuser;
            r_in_last  <= s_axis_tlast;
        end
    end

    qpp_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (r_in_valid),
        .i_byte       (r_in_byte),
        .i_first      (r_in_first),
        .i_last       (r_in_last),
        .i_def_width  (r_def_width),
        .i_def_height (r_def_height),
        .i_limit      (r_limit),
        .o_res_valid  (res_valid),
        .o_res        (res)
    );

    qpp_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_data  (res),
        .o_valid (m_axis_tvalid),
        .i_pop   (m_axis_tready),
        .o_data  (out_res),
        .o_level (level)
    );

    assign m_axis_tdata = {2'b00,
                           out_res.height_out,
                           out_res.width_out,
                           out_res.top_out,
                           out_res.left_out,
                           out_res.format_code,
                           out_res.region_flag,
                           out_res.status};

endmodule

// ===== verif/http_query_param_parser_tb.sv =====
// ----------------------------------------------------------------------------
// http_query_param_parser_tb
// feeds request targets byte by byte into the query parser: fixed routes and
// parameter strings first, then a sweep of register settings, then random
// queries with noise. a behavioral parser runs beside the block and every
// result word is checked field by field in arrival order.
// ----------------------------------------------------------------------------
module http_query_param_parser_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NO_RESULT    = -1;
    localparam int RANDOM_BYTES = 1200;
    localparam int CFG_INTERVAL = 300;
    localparam int QUIET_BYTES  = 250;
    localparam int DRAIN_CYCLES = 6;
    localparam int LIMIT_CYCLES = 400000;

    // parameter codes, format is PARAM_FORMAT
    localparam int KEY_WIDTH  = 1;
    localparam int KEY_HEIGHT = 2;
    localparam int KEY_LEFT   = 3;
    localparam int KEY_X      = 4;
    localparam int KEY_TOP    = 5;
    localparam int KEY_Y      = 6;

    localparam int SLOT_LEFT   = 0;
    localparam int SLOT_TOP    = 1;
    localparam int SLOT_WIDTH  = 2;
    localparam int SLOT_HEIGHT = 3;

    typedef enum logic [3:0] {
        P_IDLE, P_DONE, P_ROUTE, P_PIXEL, P_AFTER, P_SEG, P_NAME, P_SKIP,
        P_FMT1, P_FMT2, P_SIGN, P_DIGITS
    } t_phase;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic [7:0]  s_axis_tdata = 8'h00;  // [7:0] query_byte
    logic        s_axis_tuser = 1'b0;   // [0] first_byte
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tready = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = qpp_pkg::CFG_DEF_WIDTH;
    logic [15:0] i_cfg_data = 16'h0000;
    wire         s_axis_tready;
    wire         m_axis_tvalid;
    wire  [71:0] m_axis_tdata;          // status, region_flag, format_code, left_out,
                                        // top_out, width_out, height_out, zero pad

    http_query_param_parser dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // parser state kept beside the block
    t_phase      ph;
    logic [2:0]  mpos;
    logic [7:0]  cand;
    logic [2:0]  pend;
    logic [15:0] acc;
    logic        neg, got_digit, over;
    logic [7:0]  fmt_ch;
    logic [15:0] crd [4];
    logic [1:0]  wfmt;
    logic        wreg;
    logic [15:0] def_w, def_h, lim;

    qpp_pkg::t_result awaited [$];
    logic [7:0]  qtext [$];
    int          mismatches = 0;
    int          bytes_sent = 0;
    int          cycle_count = 0;
    bit          quiet = 1'b0;
    bit          gaps_on = 1'b1;
    bit          broken_last = 1'b0;

    // ---------------------------------------------------------------- parser

    function automatic string key_text(int code);
        case (code)
            KEY_WIDTH:                   return "width=";
            KEY_HEIGHT:                  return "height=";
            KEY_LEFT:                    return "left=";
            KEY_X:                       return "x=";
            KEY_TOP:                     return "top=";
            KEY_Y:                       return "y=";
            int'(qpp_pkg::PARAM_FORMAT): return "format=";
            default:                     return "";
        endcase
    endfunction

    function automatic int slot_of(int code);
        case (code)
            KEY_WIDTH:           return SLOT_WIDTH;
            KEY_HEIGHT:          return SLOT_HEIGHT;
            KEY_TOP, KEY_Y:      return SLOT_TOP;
            default:             return SLOT_LEFT;
        endcase
    endfunction

    function automatic bit is_end(logic [7:0] b);
        return b == " " || b == 8'h0d || b == 8'h0a;
    endfunction

    function automatic bit is_digit(logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic void model_reset();
        def_w = qpp_pkg::RST_DEF_WIDTH;
        def_h = qpp_pkg::RST_DEF_HEIGHT;
        lim = qpp_pkg::RST_LIMIT;
        ph = P_IDLE;
        mpos = '0;
        cand = 8'hff;
        pend = '0;
        acc = '0;
        {neg, got_digit, over} = '0;
        fmt_ch = '0;
        foreach (crd[i]) crd[i] = '0;
        wfmt = qpp_pkg::FMT_PNG;
        wreg = 1'b0;
    endfunction

    function automatic int skip_tail(logic [7:0] b);
        if (is_end(b)) return int'(qpp_pkg::ST_OK);
        ph = (b == "&") ? P_SEG : P_SKIP;
        return NO_RESULT;
    endfunction

    function automatic int match_name(logic [7:0] b);
        logic [7:0] keep;
        int         hit;
        string      kt;
        if (is_end(b) || b == "&") return skip_tail(b);
        keep = '0;
        hit = 0;
        for (int code = 1; code <= 7; code++) begin
            kt = key_text(code);
            if (cand[code-1] && mpos < kt.len() && kt[mpos] == b) begin
                keep[code-1] = 1'b1;
                if (mpos + 1 == kt.len()) hit = code;
            end
        end
        if (mpos < 7) mpos = mpos + 1;
        cand = keep;
        if (hit != 0) begin
            pend = hit[2:0];
            acc = '0;
            {neg, got_digit, over} = '0;
            ph = (hit == int'(qpp_pkg::PARAM_FORMAT)) ? P_FMT1 : P_SIGN;
        end else if (keep == 0) begin
            ph = P_SKIP;
        end
        return NO_RESULT;
    endfunction

    function automatic void add_digit(logic [7:0] b);
        logic [31:0] n;
        n = 32'(acc) * 10 + 32'(b) - 32'd48;
        got_digit = 1'b1;
        if (n > 32'(lim)) begin
            over = 1'b1;
            n = 32'(lim);
        end
        acc = n[15:0];
    endfunction

    function automatic int end_number();
        if (!got_digit) return int'(qpp_pkg::ST_NON_NUM);
        if (over) return int'(qpp_pkg::ST_RANGE);
        if (neg && acc != 0) return int'(qpp_pkg::ST_RANGE);
        if (acc > lim) return int'(qpp_pkg::ST_RANGE);
        crd[slot_of(int'(pend))] = acc;
        return NO_RESULT;
    endfunction

    function automatic int feed_byte(logic [7:0] b);
        string      route;
        logic [7:0] p, q;
        int         st;
        route = "/pixel/";
        case (ph)
            P_ROUTE: begin
                if (b == " ") begin
                    wreg = 1'b1;
                    return int'(qpp_pkg::ST_OK);
                end
                if (b == "?") begin
                    wreg = 1'b1;
                    ph = P_SEG;
                    return NO_RESULT;
                end
                if (b == "#") return int'(qpp_pkg::ST_NO_QM);
                if (b == "p") begin
                    ph = P_PIXEL;
                    mpos = 3'd2;
                    return NO_RESULT;
                end
                return int'(qpp_pkg::ST_ROUTE);
            end
            P_PIXEL: begin
                if (mpos < 7 && b == route[mpos]) begin
                    mpos = mpos + 1;
                    if (mpos == 7) begin
                        wreg = 1'b0;
                        ph = P_AFTER;
                    end
                    return NO_RESULT;
                end
                return int'(qpp_pkg::ST_ROUTE);
            end
            P_AFTER: begin
                if (b == " ") return int'(qpp_pkg::ST_OK);
                if (b == "?") begin
                    ph = P_SEG;
                    return NO_RESULT;
                end
                return int'(qpp_pkg::ST_NO_QM);
            end
            P_SEG: begin
                if (is_end(b) || b == 8'h00) return int'(qpp_pkg::ST_OK);
                if (b == "&") return NO_RESULT;
                ph = P_NAME;
                cand = 8'hff;
                mpos = '0;
                return match_name(b);
            end
            P_NAME: return match_name(b);
            P_SKIP: return skip_tail(b);
            P_FMT1: begin
                if (b == "t" || b == "T") begin
                    wfmt = qpp_pkg::FMT_TEXT;
                    ph = P_SKIP;
                    return NO_RESULT;
                end
                p = b | 8'h20;
                if (p == "p" || p == "i" || p == "b" || p == "j") begin
                    fmt_ch = b;
                    ph = P_FMT2;
                    return NO_RESULT;
                end
                return int'(qpp_pkg::ST_FORMAT);
            end
            P_FMT2: begin
                p = fmt_ch | 8'h20;
                q = b | 8'h20;
                if ((p == "p" && q == "n") || (p == "i" && q == "m"))
                    wfmt = qpp_pkg::FMT_PNG;
                else if (p == "b" && q == "i") wfmt = qpp_pkg::FMT_BIN;
                else if (p == "j" && q == "s") wfmt = qpp_pkg::FMT_JSON;
                else return int'(qpp_pkg::ST_FORMAT);
                ph = P_SKIP;
                return NO_RESULT;
            end
            P_SIGN: begin
                if (b == "+") begin
                    ph = P_DIGITS;
                    return NO_RESULT;
                end
                if (b == "-") begin
                    neg = 1'b1;
                    ph = P_DIGITS;
                    return NO_RESULT;
                end
                if (is_digit(b)) begin
                    add_digit(b);
                    ph = P_DIGITS;
                    return NO_RESULT;
                end
                return int'(qpp_pkg::ST_NON_NUM);
            end
            P_DIGITS: begin
                if (is_digit(b)) begin
                    add_digit(b);
                    return NO_RESULT;
                end
                st = end_number();
                if (st >= 0) return st;
                return skip_tail(b);
            end
            default: return NO_RESULT;
        endcase
    endfunction

    // data ends: judge whatever is still open
    function automatic int close_query();
        int st;
        case (ph)
            P_ROUTE, P_PIXEL: return int'(qpp_pkg::ST_ROUTE);
            P_AFTER:          return int'(qpp_pkg::ST_NO_QM);
            P_FMT1, P_FMT2:   return int'(qpp_pkg::ST_FORMAT);
            P_SIGN:           return int'(qpp_pkg::ST_NON_NUM);
            P_DIGITS: begin
                st = end_number();
                return (st >= 0) ? st : int'(qpp_pkg::ST_OK);
            end
            default:          return int'(qpp_pkg::ST_OK);
        endcase
    endfunction

    function automatic bit parse_byte(logic [7:0] b, bit first, bit last,
                                      output qpp_pkg::t_result r);
        int st;
        r = '0;
        if (first) begin
            mpos = '0;
            cand = 8'hff;
            pend = '0;
            acc = '0;
            {neg, got_digit, over} = '0;
            fmt_ch = '0;
            crd[SLOT_LEFT] = '0;
            crd[SLOT_TOP] = '0;
            crd[SLOT_WIDTH] = def_w;
            crd[SLOT_HEIGHT] = def_h;
            wfmt = qpp_pkg::FMT_PNG;
            wreg = 1'b0;
            ph = P_ROUTE;
            st = (b != "/") ? int'(qpp_pkg::ST_ROUTE) : NO_RESULT;
        end else if (ph == P_IDLE || ph == P_DONE) begin
            return 1'b0;
        end else begin
            st = feed_byte(b);
        end
        if (st < 0 && last) st = close_query();
        if (st < 0) return 1'b0;
        r.status = st[2:0];
        if (st == int'(qpp_pkg::ST_OK)) begin
            r.region_flag = wreg;
            r.format_code = wfmt;
            r.left_out = crd[SLOT_LEFT];
            r.top_out = crd[SLOT_TOP];
            r.width_out = crd[SLOT_WIDTH];
            r.height_out = crd[SLOT_HEIGHT];
        end
        ph = P_DONE;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------- checking

    task automatic check_field(string what, int unsigned want, int unsigned seen);
        if (want != seen) begin
            $display("%0t: %s expected %0d got %0d", $time, what, want, seen);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : result_check
        qpp_pkg::t_result seen, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            seen.status      = m_axis_tdata[2:0];
            seen.region_flag = m_axis_tdata[3];
            seen.format_code = m_axis_tdata[5:4];
            seen.left_out    = m_axis_tdata[21:6];
            seen.top_out     = m_axis_tdata[37:22];
            seen.width_out   = m_axis_tdata[53:38];
            seen.height_out  = m_axis_tdata[69:54];
            if (awaited.size() == 0) begin
                $display("%0t: unexpected result expected none got status %0d",
                         $time, seen.status);
                mismatches++;
            end else begin
                want = awaited.pop_front();
                check_field("status", want.status, seen.status);
                check_field("region_flag", want.region_flag, seen.region_flag);
                check_field("format_code", want.format_code, seen.format_code);
                check_field("left_out", want.left_out, seen.left_out);
                check_field("top_out", want.top_out, seen.top_out);
                check_field("width_out", want.width_out, seen.width_out);
                check_field("height_out", want.height_out, seen.height_out);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("simulation failed");
            $finish;
        end
    end

    // result side back-pressure
    always begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge i_clk);
        if (!quiet && $urandom_range(0, 2) == 0) begin
            m_axis_tready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    end

    // ------------------------------------------------------------- stimulus

    task automatic send_byte(logic [7:0] b, bit first, bit last);
        int               gap;
        qpp_pkg::t_result r;
        gap = 0;
        if (!quiet && gaps_on && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 12);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        s_axis_tuser <= first;
        s_axis_tlast <= last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (parse_byte(b, first, last, r)) awaited.push_back(r);
        bytes_sent++;
    endtask

    function automatic void push_text(string s);
        for (int i = 0; i < s.len(); i++) qtext.push_back(s[i]);
    endfunction

    task automatic send_query(bit last_at_end);
        bit last;
        for (int i = 0; i < qtext.size(); i++) begin
            last = last_at_end && i == qtext.size() - 1;
            if (broken_last && $urandom_range(0, 49) == 0) last = 1'b1;
            send_byte(qtext[i], i == 0, last);
        end
    endtask

    task automatic run_text(string s, bit last_at_end);
        qtext.delete();
        push_text(s);
        send_query(last_at_end);
    endtask

    // let every queued result out and the pipeline empty
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (awaited.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] v);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= v;
        @(posedge i_clk);
        case (idx)
            qpp_pkg::CFG_DEF_WIDTH:  def_w = v;
            qpp_pkg::CFG_DEF_HEIGHT: def_h = v;
            qpp_pkg::CFG_LIMIT:      lim = v;
            default: ;
        endcase
    endtask

    task automatic set_config(logic [15:0] w, logic [15:0] h, logic [15:0] l);
        wait_idle();
        write_reg(qpp_pkg::CFG_DEF_WIDTH, w);
        write_reg(qpp_pkg::CFG_DEF_HEIGHT, h);
        write_reg(qpp_pkg::CFG_LIMIT, l);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [15:0] pick_reg();
        case ($urandom_range(0, 3))
            0:       return 16'd0;
            1:       return 16'hffff;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic string format_word();
        case ($urandom_range(0, 15))
            0:  return "t";
            1:  return "T";
            2:  return "text";
            3:  return "png";
            4:  return "PN";
            5:  return "im";
            6:  return "Image";
            7:  return "bin";
            8:  return "BI";
            9:  return "js";
            10: return "JSON";
            11: return "x";
            12: return "p";
            13: return "jz";
            14: return "";
            default: return "Pn";
        endcase
    endfunction

    function automatic void push_number();
        int k, v;
        k = $urandom_range(0, 99);
        if (k < 3) qtext.push_back(" ");
        case ($urandom_range(0, 9))
            0: qtext.push_back("+");
            1: qtext.push_back("-");
            default: ;
        endcase
        if (k < 12) begin
            // right around the limit
            v = int'(lim) + $urandom_range(0, 2) - 1;
            if (v < 0) v = 0;
            push_text($sformatf("%0d", v));
        end else if (k >= 15) begin
            repeat ($urandom_range(0, 7) == 0 ? $urandom_range(5, 6) : $urandom_range(1, 4))
                qtext.push_back(8'($urandom_range(48, 57)));
        end
        if ($urandom_range(0, 9) == 0) qtext.push_back(8'($urandom_range(97, 122)));
    endfunction

    // fills qtext with one random request target, returns 1 to end it on tlast
    function automatic bit build_query();
        int    r, n;
        string s;
        r = $urandom_range(0, 99);
        if (r < 45) begin
            push_text("/?");
        end else if (r < 75) begin
            push_text("/pixel/?");
        end else begin
            if (r < 80) push_text("/ ");
            else if (r < 84) push_text("/pixel/ ");
            else if (r < 88) push_text("/#");
            else if (r < 94) begin
                s = "/pixel/";
                push_text(s.substr(0, $urandom_range(1, 6)));
                qtext.push_back(8'($urandom_range(0, 255)));
            end else begin
                qtext.push_back($urandom_range(0, 1) ? 8'h2f : 8'($urandom_range(0, 255)));
                repeat ($urandom_range(0, 3)) qtext.push_back(8'($urandom_range(0, 255)));
            end
            return $urandom_range(0, 1);
        end
        n = $urandom_range(0, 5);
        for (int i = 0; i < n; i++) begin
            if (i > 0) begin
                qtext.push_back("&");
                if ($urandom_range(0, 9) == 0) qtext.push_back("&");
            end
            r = $urandom_range(0, 9);
            if (r <= 5) begin
                push_text(key_text(r + 1));
                push_number();
            end else if (r <= 7) begin
                push_text(key_text(int'(qpp_pkg::PARAM_FORMAT)));
                push_text(format_word());
            end else if (r == 8) begin
                repeat ($urandom_range(1, 5)) qtext.push_back(8'($urandom_range(97, 122)));
                if ($urandom_range(0, 1)) begin
                    qtext.push_back("=");
                    push_number();
                end
            end else begin
                s = key_text($urandom_range(1, 7));
                push_text(s.substr(0, $urandom_range(0, s.len() - 2)));
            end
        end
        if ($urandom_range(0, 19) == 0)
            qtext.insert($urandom_range(1, qtext.size()), 8'($urandom_range(0, 255)));
        r = $urandom_range(0, 99);
        if (r < 35) qtext.push_back(" ");
        else if (r < 45) qtext.push_back(8'h0d);
        else if (r < 55) qtext.push_back(8'h0a);
        else if (r < 65) qtext.push_back(8'h00);
        return r >= 65 && r < 88;
    endfunction

    // ---------------------------------------------------------------- tests

    task automatic test_directed_queries();
        run_text("/ ", 1'b0);
        send_byte("z", 1'b0, 1'b0);             // ignored after the result
        run_text("x", 1'b1);
        run_text("/#", 1'b0);
        run_text("/q", 1'b0);
        run_text("/pix", 1'b1);
        run_text("/pixel/", 1'b1);
        run_text("/pixel/x", 1'b0);
        run_text("/pixel/ ", 1'b0);
        run_text("/pixel/?width=640&height=480&x=5&y=7&format=json ", 1'b0);
        run_text("/?left=10&top=20&format=T\015", 1'b0);
        run_text("/?format=Im&width=-0\n", 1'b0);
        run_text("/?format=bI&foo=1&&width=12junk&Left=3 ", 1'b0);
        run_text("/?format=xx", 1'b0);
        run_text("/?format=b", 1'b1);
        run_text("/?format", 1'b1);
        run_text("/?width=10001 ", 1'b0);
        run_text("/?height=-3 ", 1'b0);
        run_text("/?width=abc", 1'b0);
        run_text("/?width= 5", 1'b0);
        run_text("/?y=99999 ", 1'b0);
        run_text("/?width=1", 1'b1);
        // zero byte where a parameter would start
        run_text("/?", 1'b0);
        send_byte(8'h00, 1'b0, 1'b0);
        // a new first byte cuts an open query short
        run_text("/?wid", 1'b0);
        qtext.delete();
        push_text("/?x=1");
        qtext.push_back(8'hff);
        push_text("&top=+8 ");
        send_query(1'b0);
        run_text("/pixel/?format=PNG&height=0 ", 1'b0);
    endtask

    task automatic test_register_settings();
        for (int i = 0; i < 4; i++) begin
            case (i)
                0: set_config(16'd0, 16'd0, 16'd0);
                1: set_config(16'hffff, 16'hffff, 16'hffff);
                2: set_config(16'd1, 16'hfffe, 16'd1);
                default: set_config(pick_reg(), pick_reg(), pick_reg());
            endcase
            run_text("/ ", 1'b0);
            run_text("/?width=65535 ", 1'b0);
            run_text("/?height=65536&x=1 ", 1'b0);
            run_text("/?left=0&top=1&y=2 ", 1'b0);
            run_text("/pixel/?x=2", 1'b1);
        end
    endtask

    task automatic test_random_queries();
        int start, next_cfg;
        bit end_last;
        start = bytes_sent;
        next_cfg = 0;
        while (bytes_sent - start < RANDOM_BYTES) begin
            if (bytes_sent - start >= next_cfg) begin
                set_config(pick_reg(), pick_reg(), pick_reg());
                next_cfg += CFG_INTERVAL;
            end
            quiet = bytes_sent - start >= RANDOM_BYTES - QUIET_BYTES;
            gaps_on = $urandom_range(0, 3) != 0;
            broken_last = $urandom_range(0, 9) == 0;
            qtext.delete();
            end_last = build_query();
            send_query(end_last);
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(1, 3))
                    send_byte(8'($urandom_range(0, 255)), 1'b0, $urandom_range(0, 1));
        end
    endtask

    initial begin
        model_reset();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_queries();
        test_register_settings();
        test_random_queries();
        wait_idle();
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== http_query_param_parser.f =====
hw/rtl/qpp_pkg.sv
hw/rtl/qpp_parser.sv
hw/rtl/qpp_out_fifo.sv
hw/rtl/http_query_param_parser.sv
verif/http_query_param_parser_tb.sv
